@@ rtl/core/sasmd_pkg.sv @@
// shared types and constants for the signed add / sub / mul / div unit
package sasmd_pkg;

   localparam int WIDTH = 32;
   localparam int CNT_W = $clog2(WIDTH);

   localparam logic [WIDTH-1:0] INT_MIN = {1'b1, {(WIDTH-1){1'b0}}};
   localparam logic [WIDTH-1:0] INT_MAX = ~INT_MIN;
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(WIDTH - 1);

   typedef enum logic [1:0] {
      FUNC_ADD = 2'd0,
      FUNC_SUB = 2'd1,
      FUNC_MUL = 2'd2,
      FUNC_DIV = 2'd3
   } func_type;

   // one datapath operation per cycle
   typedef enum logic [3:0] {
      STEP_NONE,
      STEP_LOAD,
      STEP_ADDSUB,
      STEP_SPECIAL,
      STEP_ABS_A,
      STEP_ABS_B,
      STEP_MUL,
      STEP_DIV,
      STEP_FIX
   } step_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ABS_B,
      ST_MUL,
      ST_DIV,
      ST_FIX,
      ST_DONE
   } state_type;

   typedef struct packed {
      step_type step;
   } ctrl_type;

   typedef struct packed {
      func_type func;
      logic     div_zero;
      logic     div_ovf;
   } stat_type;

endpackage

@@ rtl/core/sasmd_if.sv @@
// request and response channel interfaces
interface sasmd_req_if;
   logic                                      valid;
   logic                                      ready;
   sasmd_pkg::func_type                       func;
   logic signed [sasmd_pkg::WIDTH-1:0]        operand_a;
   logic signed [sasmd_pkg::WIDTH-1:0]        operand_b;

   modport source (output valid, output func, output operand_a, output operand_b,
                   input ready);
   modport sink   (input valid, input func, input operand_a, input operand_b,
                   output ready);
endinterface

interface sasmd_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [sasmd_pkg::WIDTH-1:0]        result;
   logic                                      div_by_zero;
   logic                                      saturated;

   modport source (output valid, output result, output div_by_zero, output saturated,
                   input ready);
   modport sink   (input valid, input result, input div_by_zero, input saturated,
                   output ready);
endinterface

@@ rtl/core/sasmd_dpath.sv @@
// operand registers, shared adder and result register
module sasmd_dpath (
   input  logic                              clock,
   input  sasmd_pkg::ctrl_type               ctl,
   input  sasmd_pkg::func_type               in_func,
   input  logic signed [sasmd_pkg::WIDTH-1:0] in_a,
   input  logic signed [sasmd_pkg::WIDTH-1:0] in_b,
   output sasmd_pkg::stat_type               stat,
   output logic signed [sasmd_pkg::WIDTH-1:0] result,
   output logic                              div_by_zero,
   output logic                              saturated
);

   localparam int W = sasmd_pkg::WIDTH;

   sasmd_pkg::func_type func_ff, func_in;
   logic [W-1:0] a_ff, a_in;      // multiplicand, dividend / quotient
   logic [W-1:0] b_ff, b_in;      // multiplier, divisor
   logic [W-1:0] acc_ff, acc_in;  // product, remainder
   logic         neg_ff, neg_in;
   logic [W-1:0] res_ff, res_in;
   logic         dz_ff, dz_in;
   logic         sat_ff, sat_in;

   logic [W-1:0] add_x, add_y, rem_sh;
   logic         add_inv;
   logic [W:0]   sum;

   assign rem_sh = {acc_ff[W-2:0], a_ff[W-1]};

   // the one shared adder
   always_comb begin
      add_x   = '0;
      add_y   = '0;
      add_inv = 1'b0;
      case (ctl.step)
         sasmd_pkg::STEP_ADDSUB: begin
            add_x   = a_ff;
            add_y   = b_ff;
            add_inv = (func_ff == sasmd_pkg::FUNC_SUB);
         end
         sasmd_pkg::STEP_ABS_A: begin
            add_y   = a_ff;
            add_inv = 1'b1;
         end
         sasmd_pkg::STEP_ABS_B: begin
            add_y   = b_ff;
            add_inv = 1'b1;
         end
         sasmd_pkg::STEP_MUL: begin
            add_x = acc_ff;
            add_y = a_ff;
         end
         sasmd_pkg::STEP_DIV: begin
            add_x   = rem_sh;
            add_y   = b_ff;
            add_inv = 1'b1;
         end
         sasmd_pkg::STEP_FIX: begin
            add_y   = a_ff;
            add_inv = neg_ff;
         end
         default: begin
            add_inv = 1'b0;
         end
      endcase
   end

   assign sum = {1'b0, add_x} + {1'b0, (add_inv ? ~add_y : add_y)} + (W+1)'(add_inv);

   always_comb begin
      func_in = func_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      neg_in  = neg_ff;
      res_in  = res_ff;
      dz_in   = dz_ff;
      sat_in  = sat_ff;
      case (ctl.step)
         sasmd_pkg::STEP_LOAD: begin
            func_in = in_func;
            a_in    = in_a;
            b_in    = in_b;
            acc_in  = '0;
            neg_in  = in_a[W-1] ^ in_b[W-1];
         end
         sasmd_pkg::STEP_ADDSUB: begin
            res_in = sum[W-1:0];
            dz_in  = 1'b0;
            sat_in = 1'b0;
         end
         sasmd_pkg::STEP_SPECIAL: begin
            dz_in  = stat.div_zero;
            sat_in = stat.div_ovf & ~stat.div_zero;
            res_in = stat.div_zero ? '0 : sasmd_pkg::INT_MAX;
         end
         sasmd_pkg::STEP_ABS_A: begin
            if (a_ff[W-1]) begin
               a_in = sum[W-1:0];
            end
         end
         sasmd_pkg::STEP_ABS_B: begin
            if (b_ff[W-1]) begin
               b_in = sum[W-1:0];
            end
         end
         sasmd_pkg::STEP_MUL: begin
            if (b_ff[0]) begin
               acc_in = sum[W-1:0];
            end
            a_in = {a_ff[W-2:0], 1'b0};
            b_in = {1'b0, b_ff[W-1:1]};
         end
         sasmd_pkg::STEP_DIV: begin
            // carry out set means no borrow: keep the difference
            acc_in = sum[W] ? sum[W-1:0] : rem_sh;
            a_in   = {a_ff[W-2:0], sum[W]};
         end
         sasmd_pkg::STEP_FIX: begin
            res_in = (func_ff == sasmd_pkg::FUNC_MUL) ? acc_ff : sum[W-1:0];
            dz_in  = 1'b0;
            sat_in = 1'b0;
         end
         default: begin
            res_in = res_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
      neg_ff  <= neg_in;
      res_ff  <= res_in;
      dz_ff   <= dz_in;
      sat_ff  <= sat_in;
   end

   assign stat.func     = func_ff;
   assign stat.div_zero = (b_ff == '0);
   assign stat.div_ovf  = (a_ff == sasmd_pkg::INT_MIN) && (b_ff == '1);

   assign result      = res_ff;
   assign div_by_zero = dz_ff;
   assign saturated   = sat_ff;

endmodule

@@ rtl/core/sasmd_ctrl.sv @@
// sequencer: decode, iteration count and handshake control
module sasmd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  sasmd_pkg::stat_type  stat,
   output sasmd_pkg::ctrl_type  ctl
);

   sasmd_pkg::state_type state_ff, state_in;
   logic [sasmd_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic last;
   logic req_take;

   assign last     = (cnt_ff == sasmd_pkg::LAST_CNT);
   assign req_take = req_valid & req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sasmd_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = sasmd_pkg::ST_DECODE;
            end
         end
         sasmd_pkg::ST_DECODE: begin
            case (stat.func)
               sasmd_pkg::FUNC_MUL: state_in = sasmd_pkg::ST_MUL;
               sasmd_pkg::FUNC_DIV: begin
                  if (stat.div_zero || stat.div_ovf) begin
                     state_in = sasmd_pkg::ST_DONE;
                  end else begin
                     state_in = sasmd_pkg::ST_ABS_B;
                  end
               end
               default: state_in = sasmd_pkg::ST_DONE;
            endcase
         end
         sasmd_pkg::ST_ABS_B: state_in = sasmd_pkg::ST_DIV;
         sasmd_pkg::ST_MUL: begin
            if (last) begin
               state_in = sasmd_pkg::ST_FIX;
            end
         end
         sasmd_pkg::ST_DIV: begin
            if (last) begin
               state_in = sasmd_pkg::ST_FIX;
            end
         end
         sasmd_pkg::ST_FIX: state_in = sasmd_pkg::ST_DONE;
         sasmd_pkg::ST_DONE: begin
            if (rsp_ready) begin
               state_in = req_valid ? sasmd_pkg::ST_DECODE : sasmd_pkg::ST_IDLE;
            end
         end
         default: state_in = sasmd_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      ctl.step  = sasmd_pkg::STEP_NONE;
      case (state_ff)
         sasmd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.step = sasmd_pkg::STEP_LOAD;
            end
         end
         sasmd_pkg::ST_DECODE: begin
            case (stat.func)
               sasmd_pkg::FUNC_MUL: ctl.step = sasmd_pkg::STEP_NONE;
               sasmd_pkg::FUNC_DIV: begin
                  if (stat.div_zero || stat.div_ovf) begin
                     ctl.step = sasmd_pkg::STEP_SPECIAL;
                  end else begin
                     ctl.step = sasmd_pkg::STEP_ABS_A;
                  end
               end
               default: ctl.step = sasmd_pkg::STEP_ADDSUB;
            endcase
         end
         sasmd_pkg::ST_ABS_B: ctl.step = sasmd_pkg::STEP_ABS_B;
         sasmd_pkg::ST_MUL:   ctl.step = sasmd_pkg::STEP_MUL;
         sasmd_pkg::ST_DIV:   ctl.step = sasmd_pkg::STEP_DIV;
         sasmd_pkg::ST_FIX:   ctl.step = sasmd_pkg::STEP_FIX;
         sasmd_pkg::ST_DONE: begin
            rsp_valid = 1'b1;
            req_ready = rsp_ready;
            if (rsp_ready && req_valid) begin
               ctl.step = sasmd_pkg::STEP_LOAD;
            end
         end
         default: req_ready = 1'b0;
      endcase
   end

   assign cnt_in = ((state_ff == sasmd_pkg::ST_MUL) || (state_ff == sasmd_pkg::ST_DIV)) ?
                   cnt_ff + 1'b1 : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sasmd_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

`ifndef SYNTHESIS
   // the loop always runs the full operand width
   a_fix_after_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sasmd_pkg::ST_FIX) |-> ($past(cnt_ff) == sasmd_pkg::LAST_CNT))
      else $error("fix step entered before loop finished");

   a_take_decodes: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == sasmd_pkg::ST_DECODE))
      else $error("accepted transaction not decoded");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      ((state_ff != sasmd_pkg::ST_IDLE) && (state_ff != sasmd_pkg::ST_DONE)) |-> !req_ready)
      else $error("ready while an operation is in flight");

   a_loop_start: assert property (@(posedge clock) disable iff (reset)
      ($rose(state_ff == sasmd_pkg::ST_MUL) || $rose(state_ff == sasmd_pkg::ST_DIV))
      |-> (cnt_ff == '0))
      else $error("loop counter not cleared at loop start");
`endif

endmodule

@@ rtl/core/signed_int_add_sub_mul_div_top.sv @@
// top level of the signed add / subtract / multiply / divide unit
//
// usage
//  - req_chan carries one transaction: func (0 add, 1 sub, 2 mul, 3 div)
//    and two signed operands; taken when valid and ready are both high
//  - rsp_chan returns result, div_by_zero and saturated for each request,
//    in order, one response per request
//  - a single shared adder does all the arithmetic under a small sequencer
//  - add / sub and the divide special cases (zero divisor, min / -1):
//    result written in the decode state, response valid in the done state
//  - multiply: one shift-and-add pass of the adder per operand bit (32)
//    plus decode and result write
//  - divide: one restoring step per bit (32) plus decode,
//    divisor magnitude and sign fix-up
//  - one operation in flight; a new request is taken in the cycle the
//    previous response is taken, so back-to-back mul / div pass through
//    no idle state between transactions
//  - while the receiver stalls the response register holds its value and
//    no request is taken
//  - synchronous reset returns the sequencer to idle with no response valid
module signed_int_add_sub_mul_div_top (
   input  logic        clock,
   input  logic        reset,
   sasmd_req_if.sink   req_chan,
   sasmd_rsp_if.source rsp_chan
);

   sasmd_pkg::ctrl_type ctl;   // per-cycle datapath step
   sasmd_pkg::stat_type stat;  // decode status back to the sequencer

   // sequencer: owns both handshakes and the bit counter
   sasmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   // datapath: operand shifters, shared adder and response register
   sasmd_dpath u_dpath (
      .clock       (clock),
      .ctl         (ctl),
      .in_func     (req_chan.func),
      .in_a        (req_chan.operand_a),
      .in_b        (req_chan.operand_b),
      .stat        (stat),
      .result      (rsp_chan.result),
      .div_by_zero (rsp_chan.div_by_zero),
      .saturated   (rsp_chan.saturated)
   );

endmodule
